@@ rtl/avcab_pkg.sv @@
`default_nettype none
package avcab_pkg;

   typedef logic [7:0] byte_type;

   typedef enum logic [1:0] {
      ST_DONT_CARE   = 2'd0,
      ST_SPS_PPS     = 2'd1,
      ST_KEY_VIDEO   = 2'd2,
      ST_INTER_VIDEO = 2'd3
   } status_type;

   localparam logic KIND_STREAM = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   localparam byte_type KEY_FRAME_HDR   = 8'h17;
   localparam byte_type INTER_FRAME_HDR = 8'h27;
   localparam byte_type PKT_CONFIG      = 8'h00;
   localparam byte_type PKT_NALU        = 8'h01;
   localparam byte_type START_CODE_ZERO = 8'h00;
   localparam byte_type START_CODE_LAST = 8'h01;

   localparam logic [3:0] REC_LEN_SIZE_IDX  = 4'd9;
   localparam logic [3:0] REC_SPS_COUNT_IDX = 4'd10;
   localparam logic [3:0] CTS_LAST_IDX      = 4'd4;
   localparam logic [2:0] SET_LEN_BYTES     = 3'd2;

   // results caused by one accepted byte, in order: start code, data byte, status
   typedef struct packed {
      logic       emit_start;
      logic       emit_data;
      byte_type   data_byte;
      logic       emit_status;
      status_type status;
   } burst_type;

endpackage
`default_nettype wire

@@ rtl/avcab_req_if.sv @@
`default_nettype none
interface avcab_req_if;
   import avcab_pkg::*;

   logic     valid;
   logic     ready;
   byte_type body_byte;
   logic     tag_last;

   modport source (output valid, output body_byte, output tag_last, input ready);
   modport sink   (input valid, input body_byte, input tag_last, output ready);
endinterface
`default_nettype wire

@@ rtl/avcab_rsp_if.sv @@
`default_nettype none
interface avcab_rsp_if;
   import avcab_pkg::*;

   logic       valid;
   logic       ready;
   logic       kind;
   byte_type   out_byte;
   status_type status;
   logic       end_of_tag;

   modport source (output valid, output kind, output out_byte, output status,
                   output end_of_tag, input ready);
   modport sink   (input valid, input kind, input out_byte, input status,
                   input end_of_tag, output ready);
endinterface
`default_nettype wire

@@ rtl/avcab_parser.sv @@
`default_nettype none
module avcab_parser (
   input  wire logic                  clock,
   input  wire logic                  reset,
   avcab_req_if.sink                  req_chan,
   input  wire logic                  take_ok,
   output avcab_pkg::burst_type       burst,
   output logic                       burst_load
);
   import avcab_pkg::*;

   typedef enum logic [3:0] {
      PH_FIRST   = 4'd0,
      PH_TYPE    = 4'd1,
      PH_RECHDR  = 4'd2,
      PH_SPSLEN  = 4'd3,
      PH_SPSDATA = 4'd4,
      PH_PPSCNT  = 4'd5,
      PH_PPSLEN  = 4'd6,
      PH_PPSDATA = 4'd7,
      PH_RECDONE = 4'd8,
      PH_CTS     = 4'd9,
      PH_NALEN   = 4'd10,
      PH_NADATA  = 4'd11,
      PH_SKIP    = 4'd12
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [3:0]  hdr_idx_ff, hdr_idx_in;
   status_type  tag_class_ff, tag_class_in;
   logic [2:0]  len_size_ff, len_size_in;
   logic        config_seen_ff, config_seen_in;
   logic [7:0]  sets_left_ff, sets_left_in;
   logic [31:0] len_accum_ff, len_accum_in;
   logic [31:0] payload_left_ff, payload_left_in;
   logic [2:0]  len_bytes_ff, len_bytes_in;
   logic        error_ff, error_in;

   logic        fire;
   byte_type    b;
   logic [15:0] set_len;
   logic [31:0] nal_len;
   logic [7:0]  sets_dec;
   logic [31:0] payload_dec;
   logic        complete;
   status_type  tag_status;

   assign req_chan.ready = take_ok;
   assign fire           = req_chan.valid && take_ok;
   assign b              = req_chan.body_byte;
   assign set_len        = {len_accum_ff[7:0], b};
   assign nal_len        = {len_accum_ff[23:0], b};
   assign sets_dec       = sets_left_ff - 8'd1;
   assign payload_dec    = payload_left_ff - 32'd1;
   assign burst_load     = fire && (burst.emit_start || burst.emit_data || burst.emit_status);

   always_comb begin
      phase_in        = phase_ff;
      hdr_idx_in      = hdr_idx_ff;
      tag_class_in    = tag_class_ff;
      len_size_in     = len_size_ff;
      config_seen_in  = config_seen_ff;
      sets_left_in    = sets_left_ff;
      len_accum_in    = len_accum_ff;
      payload_left_in = payload_left_ff;
      len_bytes_in    = len_bytes_ff;
      error_in        = error_ff;
      burst           = '0;
      burst.data_byte = b;
      complete        = 1'b0;
      tag_status      = ST_DONT_CARE;

      case (phase_ff)
         PH_FIRST: begin
            error_in   = 1'b0;
            hdr_idx_in = 4'd1;
            if (b == KEY_FRAME_HDR) begin
               tag_class_in = ST_KEY_VIDEO;
               phase_in     = PH_TYPE;
            end else if (b == INTER_FRAME_HDR) begin
               tag_class_in = ST_INTER_VIDEO;
               phase_in     = config_seen_ff ? PH_TYPE : PH_SKIP;
            end else begin
               tag_class_in = ST_DONT_CARE;
               phase_in     = PH_SKIP;
            end
         end
         PH_TYPE: begin
            hdr_idx_in = 4'd2;
            if (b == PKT_CONFIG && tag_class_ff == ST_KEY_VIDEO) begin
               tag_class_in = ST_SPS_PPS;
               phase_in     = PH_RECHDR;
            end else if (b == PKT_NALU) begin
               phase_in = PH_CTS;
            end else begin
               error_in = 1'b1;
               phase_in = PH_SKIP;
            end
         end
         PH_RECHDR: begin
            if (hdr_idx_ff == REC_LEN_SIZE_IDX) begin
               len_size_in = {1'b0, b[1:0]} + 3'd1;
            end else if (hdr_idx_ff == REC_SPS_COUNT_IDX) begin
               sets_left_in     = {3'b000, b[4:0]};
               burst.emit_start = 1'b1;
               if (b[4:0] == 5'd0) begin
                  phase_in = PH_PPSCNT;
               end else begin
                  phase_in     = PH_SPSLEN;
                  len_bytes_in = SET_LEN_BYTES;
                  len_accum_in = '0;
               end
            end
            hdr_idx_in = hdr_idx_ff + 4'd1;
         end
         PH_SPSLEN, PH_PPSLEN: begin
            len_accum_in = {16'd0, set_len};
            len_bytes_in = len_bytes_ff - 3'd1;
            if (len_bytes_ff == 3'd1) begin
               payload_left_in = {16'd0, set_len};
               if (set_len == 16'd0) begin
                  // empty set: close it right away
                  sets_left_in = sets_dec;
                  if (sets_dec != 8'd0) begin
                     phase_in     = phase_ff;
                     len_bytes_in = SET_LEN_BYTES;
                     len_accum_in = '0;
                  end else begin
                     phase_in = (phase_ff == PH_SPSLEN) ? PH_PPSCNT : PH_RECDONE;
                  end
               end else begin
                  phase_in = (phase_ff == PH_SPSLEN) ? PH_SPSDATA : PH_PPSDATA;
               end
            end
         end
         PH_SPSDATA, PH_PPSDATA: begin
            // only the last set of each kind reaches the stream
            burst.emit_data = (sets_left_ff == 8'd1);
            payload_left_in = payload_dec;
            if (payload_dec == 32'd0) begin
               sets_left_in = sets_dec;
               if (sets_dec != 8'd0) begin
                  phase_in     = (phase_ff == PH_SPSDATA) ? PH_SPSLEN : PH_PPSLEN;
                  len_bytes_in = SET_LEN_BYTES;
                  len_accum_in = '0;
               end else begin
                  phase_in = (phase_ff == PH_SPSDATA) ? PH_PPSCNT : PH_RECDONE;
               end
            end
         end
         PH_PPSCNT: begin
            burst.emit_start = 1'b1;
            sets_left_in     = b;
            if (b == 8'd0) begin
               phase_in = PH_RECDONE;
            end else begin
               phase_in     = PH_PPSLEN;
               len_bytes_in = SET_LEN_BYTES;
               len_accum_in = '0;
            end
         end
         PH_CTS: begin
            if (hdr_idx_ff >= CTS_LAST_IDX) begin
               phase_in     = PH_NALEN;
               len_bytes_in = len_size_ff;
               len_accum_in = '0;
            end else begin
               hdr_idx_in = hdr_idx_ff + 4'd1;
            end
         end
         PH_NALEN: begin
            if (len_size_ff == 3'd0 || len_bytes_ff == 3'd0) begin
               error_in = 1'b1;
               phase_in = PH_SKIP;
            end else begin
               len_accum_in = nal_len;
               len_bytes_in = len_bytes_ff - 3'd1;
               if (len_bytes_ff == 3'd1) begin
                  burst.emit_start = 1'b1;
                  payload_left_in  = nal_len;
                  if (nal_len == 32'd0) begin
                     phase_in     = PH_NALEN;
                     len_bytes_in = len_size_ff;
                     len_accum_in = '0;
                  end else begin
                     phase_in = PH_NADATA;
                  end
               end
            end
         end
         PH_NADATA: begin
            burst.emit_data = 1'b1;
            payload_left_in = payload_dec;
            if (payload_dec == 32'd0) begin
               phase_in     = PH_NALEN;
               len_bytes_in = len_size_ff;
               len_accum_in = '0;
            end
         end
         default: begin
         end
      endcase

      if (req_chan.tag_last) begin
         complete = (phase_in == PH_RECDONE) || (phase_in == PH_SKIP) ||
                    (phase_in == PH_NALEN && len_bytes_in == len_size_in);
         tag_status = (error_in || !complete) ? ST_DONT_CARE : tag_class_in;
         if (tag_status == ST_SPS_PPS) begin
            config_seen_in = 1'b1;
         end
         burst.emit_status = 1'b1;
         burst.status      = tag_status;
         phase_in          = PH_FIRST;
         hdr_idx_in        = 4'd0;
         error_in          = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_FIRST;
         hdr_idx_ff      <= '0;
         tag_class_ff    <= ST_DONT_CARE;
         len_size_ff     <= '0;
         config_seen_ff  <= 1'b0;
         sets_left_ff    <= '0;
         len_accum_ff    <= '0;
         payload_left_ff <= '0;
         len_bytes_ff    <= '0;
         error_ff        <= 1'b0;
      end else if (fire) begin
         phase_ff        <= phase_in;
         hdr_idx_ff      <= hdr_idx_in;
         tag_class_ff    <= tag_class_in;
         len_size_ff     <= len_size_in;
         config_seen_ff  <= config_seen_in;
         sets_left_ff    <= sets_left_in;
         len_accum_ff    <= len_accum_in;
         payload_left_ff <= payload_left_in;
         len_bytes_ff    <= len_bytes_in;
         error_ff        <= error_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/avcab_sequencer.sv @@
`default_nettype none
module avcab_sequencer (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire avcab_pkg::burst_type  burst,
   input  wire logic                  burst_load,
   output logic                       take_ok,
   avcab_rsp_if.source                rsp_chan
);
   import avcab_pkg::*;

   burst_type  pend_ff;
   logic       pend_valid_ff, pend_valid_in;
   logic [2:0] step_ff, step_in;
   logic [2:0] count;
   logic       last_step;
   logic       advance;

   assign count = (pend_ff.emit_start ? 3'd4 : 3'd0) + {2'b00, pend_ff.emit_data} +
                  {2'b00, pend_ff.emit_status};
   assign last_step = (step_ff == count - 3'd1);
   assign advance   = pend_valid_ff && rsp_chan.ready;
   assign take_ok   = !pend_valid_ff || (advance && last_step);

   assign rsp_chan.valid = pend_valid_ff;

   always_comb begin
      rsp_chan.kind       = KIND_STATUS;
      rsp_chan.out_byte   = '0;
      rsp_chan.status     = pend_ff.status;
      rsp_chan.end_of_tag = 1'b1;
      if (pend_ff.emit_start && step_ff <= 3'd3) begin
         rsp_chan.kind       = KIND_STREAM;
         rsp_chan.out_byte   = (step_ff == 3'd3) ? START_CODE_LAST : START_CODE_ZERO;
         rsp_chan.status     = ST_DONT_CARE;
         rsp_chan.end_of_tag = 1'b0;
      end else if (pend_ff.emit_data && step_ff == 3'd0) begin
         rsp_chan.kind       = KIND_STREAM;
         rsp_chan.out_byte   = pend_ff.data_byte;
         rsp_chan.status     = ST_DONT_CARE;
         rsp_chan.end_of_tag = 1'b0;
      end
   end

   always_comb begin
      pend_valid_in = pend_valid_ff;
      step_in       = step_ff;
      if (take_ok) begin
         // burst done or empty: take the next one
         pend_valid_in = burst_load;
         step_in       = 3'd0;
      end else if (advance) begin
         step_in = step_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         step_ff       <= '0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         step_ff       <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_ok && burst_load) begin
         pend_ff <= burst;
      end
   end

endmodule
`default_nettype wire

@@ rtl/avc_tag_to_annexb_converter.sv @@
// The first result of a byte appears in the cycle after its transfer.
// One byte per cycle while each byte yields at most one result and rsp_chan is
// ready; a start-code byte holds the result register for its four code bytes (and
// a tag-end status), a data byte with status for both; input is held meanwhile.
// Reset: synchronous, active high; clears the parse state and any pending results.
`default_nettype none
module avc_tag_to_annexb_converter (
   input  wire logic   clock,
   input  wire logic   reset,
   avcab_req_if.sink   req_chan,
   avcab_rsp_if.source rsp_chan
);
   import avcab_pkg::*;

   burst_type burst;
   logic      burst_load;
   logic      take_ok;

   avcab_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .take_ok    (take_ok),
      .burst      (burst),
      .burst_load (burst_load)
   );

   avcab_sequencer u_sequencer (
      .clock      (clock),
      .reset      (reset),
      .burst      (burst),
      .burst_load (burst_load),
      .take_ok    (take_ok),
      .rsp_chan   (rsp_chan)
   );

endmodule
`default_nettype wire
